/* src/aar_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_pkg
// Shared widths, types and arithmetic helpers of the axis-angle rotation block
// ---------------------------------------------------------------------------
package aar_pkg;

    localparam int COORD_W          = 32;
    localparam int ANGLE_W          = 26;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CW               = 34;
    localparam int SUM_W            = 64;
    localparam int ROOT_W           = SUM_W / 2;
    localparam int MAG_W            = 31;
    localparam int QUO_W            = 31;
    localparam int REM_W            = ROOT_W + 2;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    // arctangent of 2^-i in units of 2^-24 degree
    function automatic logic signed [CW-1:0] atan_step(input int i);
        logic [63:0] t;
        case (i)
            0:       t = 64'd754974720;
            1:       t = 64'd445687602;
            2:       t = 64'd235489088;
            3:       t = 64'd119537938;
            4:       t = 64'd60000934;
            5:       t = 64'd30029717;
            6:       t = 64'd15018523;
            7:       t = 64'd7509720;
            8:       t = 64'd3754917;
            9:       t = 64'd1877466;
            10:      t = 64'd938734;
            default: t = (64'd961263669 + (64'd1 << (i - 1))) >> i;
        endcase
        return $signed(t[CW-1:0]);
    endfunction

    // q30 product rounded back to q30
    function automatic logic signed [CW-1:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd536870912;
        return t[CW+29:30];
    endfunction

    // drop 14 fraction bits with rounding, then saturate to 32 bits
    function automatic logic [31:0] rnd14_sat(input logic signed [55:0] v);
        logic signed [55:0] a;
        a = v + 56'sd8192;
        a = a >>> 14;
        if (a > 56'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (a < -56'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return a[31:0];
        end
    endfunction

endpackage

/* src/aar_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_in_if
// Request channel: two axis points and an angle in degrees
// ---------------------------------------------------------------------------
interface aar_in_if;
    import aar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    logic signed [COORD_W-1:0]  qz;
    logic signed [ANGLE_W-1:0]  angle_deg;

    modport source (output valid, px, py, pz, qx, qy, qz, angle_deg, input ready);
    modport sink   (input valid, px, py, pz, qx, qy, qz, angle_deg, output ready);
endinterface

/* src/aar_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_out_if
// Result channel: top three rows of the homogeneous rotation matrix
// ---------------------------------------------------------------------------
interface aar_out_if;
    import aar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  m00, m01, m02, m03;
    logic signed [COORD_W-1:0]  m10, m11, m12, m13;
    logic signed [COORD_W-1:0]  m20, m21, m22, m23;

    modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                    m20, m21, m22, m23, input ready);
    modport sink   (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                    m20, m21, m22, m23, output ready);
endinterface

/* src/aar_sqrt_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_sqrt_cell
// One root bit of the integer square root, two radicand bits per cell
// ---------------------------------------------------------------------------
module aar_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [aar_pkg::SUM_W-1:0]   i_x,
    input  logic [aar_pkg::REM_W-1:0]   i_rem,
    input  logic [aar_pkg::ROOT_W-1:0]  i_root,
    output logic [aar_pkg::SUM_W-1:0]   o_x,
    output logic [aar_pkg::REM_W-1:0]   o_rem,
    output logic [aar_pkg::ROOT_W-1:0]  o_root
);
    import aar_pkg::*;

    logic [REM_W+1:0]  rem_s;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [SUM_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SUM_W-1:0]  n_x;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;

    always_comb begin
        rem_s  = {i_rem, i_x[SUM_W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = (rem_s >= trial);
        n_rem  = ge ? REM_W'(rem_s - trial) : REM_W'(rem_s);
        n_root = {i_root[ROOT_W-2:0], ge};
        n_x    = {i_x[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_x    = r_x;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

/* src/aar_div_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_div_cell
// One quotient bit of restoring division for the three axis components
// ---------------------------------------------------------------------------
module aar_div_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [aar_pkg::ROOT_W-1:0]          i_n,
    input  logic [2:0][aar_pkg::ROOT_W-1:0]     i_rem,
    input  logic [2:0][aar_pkg::QUO_W-1:0]      i_rest,
    input  logic [2:0][aar_pkg::QUO_W-1:0]      i_q,
    output logic [aar_pkg::ROOT_W-1:0]          o_n,
    output logic [2:0][aar_pkg::ROOT_W-1:0]     o_rem,
    output logic [2:0][aar_pkg::QUO_W-1:0]      o_rest,
    output logic [2:0][aar_pkg::QUO_W-1:0]      o_q
);
    import aar_pkg::*;

    logic [ROOT_W:0]               rem_s [3];
    logic [2:0]                    ge;
    logic [ROOT_W-1:0]             r_n;
    logic [2:0][ROOT_W-1:0]        r_rem;
    logic [2:0][QUO_W-1:0]         r_rest;
    logic [2:0][QUO_W-1:0]         r_q;
    logic [2:0][ROOT_W-1:0]        n_rem;
    logic [2:0][QUO_W-1:0]         n_rest;
    logic [2:0][QUO_W-1:0]         n_q;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_s[k]  = {i_rem[k], i_rest[k][QUO_W-1]};
            ge[k]     = (rem_s[k] >= {1'b0, i_n});
            n_rem[k]  = ge[k] ? ROOT_W'(rem_s[k] - {1'b0, i_n}) : ROOT_W'(rem_s[k]);
            n_rest[k] = {i_rest[k][QUO_W-2:0], 1'b0};
            n_q[k]    = {i_q[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= i_n;
            r_rem  <= n_rem;
            r_rest <= n_rest;
            r_q    <= n_q;
        end
    end

    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_rest = r_rest;
    assign o_q    = r_q;
endmodule

/* src/aar_cordic_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aar_cordic_cell
// One rotation-mode CORDIC micro-rotation
// ---------------------------------------------------------------------------
module aar_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  aar_pkg::t_cordic i_v,
    output aar_pkg::t_cordic o_v
);
    import aar_pkg::*;

    localparam logic signed [CW-1:0] ATAN = atan_step(IDX);

    t_cordic r_v;
    t_cordic n_v;

    always_comb begin
        if (i_v.z >= 0) begin
            n_v.x = i_v.x - (i_v.y >>> IDX);
            n_v.y = i_v.y + (i_v.x >>> IDX);
            n_v.z = i_v.z - ATAN;
        end else begin
            n_v.x = i_v.x + (i_v.y >>> IDX);
            n_v.y = i_v.y - (i_v.x >>> IDX);
            n_v.z = i_v.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;
endmodule

/* src/axis_angle_rotation_matrix.sv */
`timescale 1ns / 1ps
// 76 pipeline stages plus the output register lie between request accept and
// result valid; the first stage loads at the accepting edge
// one request per cycle while the skid is empty; all stages advance together
// a two-entry output register and skid keep intake going while a result waits
// reset clears the stage valid bits and the output/skid flags only
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation about the line through two points: axis normalization, CORDIC
// cosine and sine, and the Rodrigues matrix with its translation column
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STEPS = aar_pkg::CORDIC_STEPS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    aar_in_if.sink  i_in,
    aar_out_if.source o_out
);
    import aar_pkg::*;

    localparam int SQ_CELLS = ROOT_W;
    localparam int DV_CELLS = QUO_W;
    localparam int SIDE_N   = SQ_CELLS + DV_CELLS + 3;
    localparam int DIV_TAP  = SQ_CELLS + 2;
    localparam int CSD_N    = SIDE_N - CORDIC_STEPS;
    localparam int NST      = SIDE_N + 10;

    localparam logic signed [35:0] DEG_FULL  = 36'sd6039797760;
    localparam logic signed [35:0] DEG_HALF  = 36'sd3019898880;
    localparam logic signed [35:0] DEG_QUART = 36'sd1509949440;
    localparam logic signed [CW-1:0] ONE30   = 34'sd1073741824;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;
        logic [2:0]              neg;
        logic                    zero;
        logic [2:0][MAG_W-1:0]   m;
    } t_side;

    typedef logic [11:0][COORD_W-1:0] t_res;

    function automatic logic [4:0] lzc31(input logic [MAG_W-1:0] v);
        logic [4:0] z;
        z = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (v[b]) begin
                z = 5'(MAG_W - 1 - b);
            end
        end
        return z;
    endfunction

    logic en;
    logic in_acc;
    logic [NST-1:0] r_vld;
    logic r_out_v;
    logic r_skid_v;

    assign en          = !r_skid_v;
    assign i_in.ready  = en;
    assign in_acc      = i_in.valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], in_acc};
        end
    end

    // stage 1: capture, axis direction
    logic signed [COORD_W-1:0] r1_p [3];
    logic signed [COORD_W:0]   r1_d [3];
    logic signed [ANGLE_W-1:0] r1_ang;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= i_in.px;
            r1_p[1] <= i_in.py;
            r1_p[2] <= i_in.pz;
            r1_d[0] <= (COORD_W+1)'(i_in.qx) - (COORD_W+1)'(i_in.px);
            r1_d[1] <= (COORD_W+1)'(i_in.qy) - (COORD_W+1)'(i_in.py);
            r1_d[2] <= (COORD_W+1)'(i_in.qz) - (COORD_W+1)'(i_in.pz);
            r1_ang  <= i_in.angle_deg;
        end
    end

    // stage 2: magnitudes and largest one
    logic [COORD_W:0]     r2_m [3];
    logic [2:0]           r2_neg;
    logic [COORD_W:0]     r2_mx;
    logic [2:0][COORD_W-1:0] r2_p;
    logic [COORD_W:0]     mag [3];
    logic [COORD_W:0]     mx01;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = r1_d[k][COORD_W] ? (COORD_W+1)'(-r1_d[k]) : (COORD_W+1)'(r1_d[k]);
        end
        mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_m[k]   <= mag[k];
                r2_neg[k] <= r1_d[k][COORD_W];
                r2_p[k]   <= r1_p[k];
            end
            r2_mx <= (mx01 > mag[2]) ? mx01 : mag[2];
        end
    end

    // stage 3: common scaling so the largest magnitude lands in [2^30, 2^31)
    t_side r_side [SIDE_N];
    t_side side0;
    logic [4:0] lz;
    logic big;

    always_comb begin
        big        = (r2_mx[COORD_W:MAG_W] != '0);
        lz         = lzc31(r2_mx[MAG_W-1:0]);
        side0.p    = r2_p;
        side0.neg  = r2_neg;
        side0.zero = (r2_mx == '0);
        for (int k = 0; k < 3; k++) begin
            if (big) begin
                side0.m[k] = MAG_W'(r2_m[k] >> 1);
            end else begin
                side0.m[k] = MAG_W'(r2_m[k] << lz);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side0;
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stages 4-5: sum of squares
    logic [2*MAG_W-1:0] r4_sq [3];
    logic [SUM_W-1:0]   r5_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_sq[k] <= r_side[0].m[k] * r_side[0].m[k];
            end
            r5_sum <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
        end
    end

    // square root cell row
    logic [SUM_W-1:0]  sq_x    [SQ_CELLS+1];
    logic [REM_W-1:0]  sq_rem  [SQ_CELLS+1];
    logic [ROOT_W-1:0] sq_root [SQ_CELLS+1];

    assign sq_x[0]    = r5_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
        aar_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (sq_x[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .o_x    (sq_x[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1])
        );
    end

    // divider cell row: unit component = m * 2^30 / n
    logic [ROOT_W-1:0]         dv_n    [DV_CELLS+1];
    logic [2:0][ROOT_W-1:0]    dv_rem  [DV_CELLS+1];
    logic [2:0][QUO_W-1:0]     dv_rest [DV_CELLS+1];
    logic [2:0][QUO_W-1:0]     dv_q    [DV_CELLS+1];

    always_comb begin
        dv_n[0] = sq_root[SQ_CELLS];
        for (int k = 0; k < 3; k++) begin
            dv_rem[0][k]  = ROOT_W'(r_side[DIV_TAP].m[k] >> 1);
            dv_rest[0][k] = {r_side[DIV_TAP].m[k][0], (QUO_W-1)'(0)};
            dv_q[0][k]    = '0;
        end
    end

    for (genvar g = 0; g < DV_CELLS; g++) begin : g_div
        aar_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_n    (dv_n[g]),
            .i_rem  (dv_rem[g]),
            .i_rest (dv_rest[g]),
            .i_q    (dv_q[g]),
            .o_n    (dv_n[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_rest (dv_rest[g+1]),
            .o_q    (dv_q[g+1])
        );
    end

    // angle reduction to [-90, 90] with sign flip
    logic signed [35:0] za;
    logic signed [35:0] zb;
    logic signed [35:0] zc;
    logic               flip;
    t_cordic            r_a;
    logic               r_flip [CORDIC_STEPS+1];

    always_comb begin
        za = $signed({{2{r1_ang[ANGLE_W-1]}}, r1_ang, 8'b0});
        if (za >= DEG_HALF) begin
            zb = za - DEG_FULL;
        end else if (za < -DEG_HALF) begin
            zb = za + DEG_FULL;
        end else begin
            zb = za;
        end
        flip = 1'b0;
        zc   = zb;
        if (zb > DEG_QUART) begin
            zc   = zb - DEG_HALF;
            flip = 1'b1;
        end else if (zb < -DEG_QUART) begin
            zc   = zb + DEG_HALF;
            flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a.x     <= CORDIC_X0;
            r_a.y     <= '0;
            r_a.z     <= CW'(zc);
            r_flip[0] <= flip;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_flip[k] <= r_flip[k-1];
            end
        end
    end

    t_cordic cv [CORDIC_STEPS+1];
    assign cv[0] = r_a;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        aar_cordic_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (cv[g]),
            .o_v   (cv[g+1])
        );
    end

    // cosine and sine, delayed to meet the unit vector
    logic signed [COORD_W-1:0] r_csd_c [CSD_N];
    logic signed [COORD_W-1:0] r_csd_s [CSD_N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_csd_c[0] <= r_flip[CORDIC_STEPS] ? COORD_W'(-cv[CORDIC_STEPS].x)
                                               : COORD_W'(cv[CORDIC_STEPS].x);
            r_csd_s[0] <= r_flip[CORDIC_STEPS] ? COORD_W'(-cv[CORDIC_STEPS].y)
                                               : COORD_W'(cv[CORDIC_STEPS].y);
            for (int k = 1; k < CSD_N; k++) begin
                r_csd_c[k] <= r_csd_c[k-1];
                r_csd_s[k] <= r_csd_s[k-1];
            end
        end
    end

    // signed unit vector
    logic signed [COORD_W-1:0] ru_u [3];
    logic signed [COORD_W-1:0] ru_p [3];
    logic signed [COORD_W-1:0] ru_c;
    logic signed [COORD_W-1:0] ru_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_side[SIDE_N-1].zero) begin
                    ru_u[k] <= '0;
                end else if (r_side[SIDE_N-1].neg[k]) begin
                    ru_u[k] <= -$signed({1'b0, dv_q[DV_CELLS][k]});
                end else begin
                    ru_u[k] <= $signed({1'b0, dv_q[DV_CELLS][k]});
                end
                ru_p[k] <= r_side[SIDE_N-1].p[k];
            end
            ru_c <= r_csd_c[CSD_N-1];
            ru_s <= r_csd_s[CSD_N-1];
        end
    end

    // P1: outer products of the unit vector, 1 - cos
    logic signed [CW-1:0]      p1_uu, p1_vv, p1_ww, p1_uv, p1_uw, p1_vw, p1_omc;
    logic signed [COORD_W-1:0] p1_u [3];
    logic signed [COORD_W-1:0] p1_p [3];
    logic signed [COORD_W-1:0] p1_c, p1_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            p1_uu  <= rnd30(ru_u[0] * ru_u[0]);
            p1_vv  <= rnd30(ru_u[1] * ru_u[1]);
            p1_ww  <= rnd30(ru_u[2] * ru_u[2]);
            p1_uv  <= rnd30(ru_u[0] * ru_u[1]);
            p1_uw  <= rnd30(ru_u[0] * ru_u[2]);
            p1_vw  <= rnd30(ru_u[1] * ru_u[2]);
            p1_omc <= ONE30 - ru_c;
            p1_u   <= ru_u;
            p1_p   <= ru_p;
            p1_c   <= ru_c;
            p1_s   <= ru_s;
        end
    end

    // P2: diagonal pair sums
    logic signed [CW-1:0]      p2_sa, p2_sb, p2_sc;
    logic signed [CW-1:0]      p2_uu, p2_vv, p2_ww, p2_uv, p2_uw, p2_vw, p2_omc;
    logic signed [COORD_W-1:0] p2_u [3];
    logic signed [COORD_W-1:0] p2_p [3];
    logic signed [COORD_W-1:0] p2_c, p2_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            p2_sa  <= p1_vv + p1_ww;
            p2_sb  <= p1_uu + p1_ww;
            p2_sc  <= p1_uu + p1_vv;
            p2_uu  <= p1_uu;
            p2_vv  <= p1_vv;
            p2_ww  <= p1_ww;
            p2_uv  <= p1_uv;
            p2_uw  <= p1_uw;
            p2_vw  <= p1_vw;
            p2_omc <= p1_omc;
            p2_u   <= p1_u;
            p2_p   <= p1_p;
            p2_c   <= p1_c;
            p2_s   <= p1_s;
        end
    end

    // P3: products with cos, 1 - cos and sin
    logic signed [CW-1:0]      p3_ka, p3_kb, p3_kc, p3_uvo, p3_uwo, p3_vwo;
    logic signed [CW-1:0]      p3_us, p3_vs, p3_ws, p3_uu, p3_vv, p3_ww;
    logic signed [COORD_W-1:0] p3_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            p3_ka  <= rnd30(p2_sa * p2_c);
            p3_kb  <= rnd30(p2_sb * p2_c);
            p3_kc  <= rnd30(p2_sc * p2_c);
            p3_uvo <= rnd30(p2_uv * p2_omc);
            p3_uwo <= rnd30(p2_uw * p2_omc);
            p3_vwo <= rnd30(p2_vw * p2_omc);
            p3_us  <= rnd30(p2_u[0] * p2_s);
            p3_vs  <= rnd30(p2_u[1] * p2_s);
            p3_ws  <= rnd30(p2_u[2] * p2_s);
            p3_uu  <= p2_uu;
            p3_vv  <= p2_vv;
            p3_ww  <= p2_ww;
            p3_p   <= p2_p;
        end
    end

    // P4: rotation entries in q30
    logic signed [CW:0]        p4_r [3][3];
    logic signed [COORD_W-1:0] p4_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            p4_r[0][0] <= p3_uu + p3_ka;
            p4_r[0][1] <= p3_uvo - p3_ws;
            p4_r[0][2] <= p3_uwo + p3_vs;
            p4_r[1][0] <= p3_uvo + p3_ws;
            p4_r[1][1] <= p3_vv + p3_kb;
            p4_r[1][2] <= p3_vwo - p3_us;
            p4_r[2][0] <= p3_uwo - p3_vs;
            p4_r[2][1] <= p3_vwo + p3_us;
            p4_r[2][2] <= p3_ww + p3_kc;
            p4_p       <= p3_p;
        end
    end

    // P5: q16.16 entries and entry-times-point products
    logic [COORD_W-1:0]        p5_e [3][3];
    logic signed [CW+COORD_W:0] p5_rp [3][3];
    logic signed [COORD_W-1:0] p5_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p5_e[i][j]  <= rnd14_sat(56'(p4_r[i][j]));
                    p5_rp[i][j] <= p4_r[i][j] * p4_p[j];
                end
            end
            p5_p <= p4_p;
        end
    end

    // P6: row sums of the products, each floored by 14 bits
    logic signed [55:0]        p6_acc [3];
    logic [COORD_W-1:0]        p6_e [3][3];
    logic signed [COORD_W-1:0] p6_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p6_acc[i] <= 56'(p5_rp[i][0] >>> 14) + 56'(p5_rp[i][1] >>> 14)
                           + 56'(p5_rp[i][2] >>> 14);
            end
            p6_e <= p5_e;
            p6_p <= p5_p;
        end
    end

    // P7: translation column, result assembly
    t_res p7_res;
    logic signed [55:0] tsub [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tsub[i] = $signed({{10{p6_p[i][COORD_W-1]}}, p6_p[i], 14'b0}) - p6_acc[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p7_res[i*4+j] <= p6_e[i][j];
                end
                p7_res[i*4+3] <= rnd14_sat(tsub[i]);
            end
        end
    end

    // output register and skid
    t_res r_out;
    t_res r_skid;
    logic tail_mv;
    logic take;

    assign tail_mv = en && r_vld[NST-1];
    assign take    = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (tail_mv) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_mv) begin
            if (!r_out_v || take) begin
                r_out <= p7_res;
            end else begin
                r_skid <= p7_res;
            end
        end else if (r_skid_v && take) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.m00   = r_out[0];
    assign o_out.m01   = r_out[1];
    assign o_out.m02   = r_out[2];
    assign o_out.m03   = r_out[3];
    assign o_out.m10   = r_out[4];
    assign o_out.m11   = r_out[5];
    assign o_out.m12   = r_out[6];
    assign o_out.m13   = r_out[7];
    assign o_out.m20   = r_out[8];
    assign o_out.m21   = r_out[9];
    assign o_out.m22   = r_out[10];
    assign o_out.m23   = r_out[11];
endmodule
